>>> rtl/ldq_pkg.sv
// ldq_pkg: shared types and constants for the linear array deque
// operation codes, status codes and default sizes; no dependencies
`default_nettype none

package ldq_pkg;

    localparam int DEPTH_DEF  = 8;
    localparam int DATA_W_DEF = 32;
    localparam int VALUE_W    = 32;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 2'd0,
        FN_INS_REAR  = 2'd1,
        FN_DEL_FRONT = 2'd2,
        FN_DEL_REAR  = 2'd3
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_NO_ROOM = 2'd2,
        ST_EMPTY   = 2'd3
    } t_status;

endpackage

`default_nettype wire

>>> rtl/linear_array_deque_top.sv
// linear_array_deque_top: double-ended queue kept in a linear, non-wrapping array
// depends on ldq_pkg for operation codes, status codes and default sizes
`default_nettype none

// A command is taken at a rising edge where start is high and busy is low. Each
// command (insert front, insert rear, delete front, delete rear) gives exactly one
// result, shown on o_status, o_removed_value and o_occupancy for one cycle with
// o_valid high, in the cycle after the command was taken. The receiver cannot hold
// results off and need not: a new item may be given in every cycle while busy is
// low, so the block sustains one item per clock. busy is high only during reset
// and in the cycle after it. The array does not wrap: an insert fails with status
// no room when its own end has reached the array edge, even if the other end has
// space. Entries are not cleared at reset; only live entries are ever read.
module linear_array_deque_top #(
    parameter int DEPTH      = ldq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = ldq_pkg::DATA_W_DEF,
    parameter int OCC_W      = $clog2(DEPTH + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ldq_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [ldq_pkg::VALUE_W-1:0]   i_value,
    output logic                               o_valid,
    output logic [ldq_pkg::STATUS_W-1:0]       o_status,
    output logic [ldq_pkg::VALUE_W-1:0]        o_removed_value,
    output logic [OCC_W-1:0]                   o_occupancy
);
    import ldq_pkg::*;

    localparam int IDX_W   = $clog2(DEPTH);
    // stored width: bits above the value port are always zero, so never kept
    localparam int STORE_W = (DATA_WIDTH < VALUE_W) ? DATA_WIDTH : VALUE_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    // pointer state in flops, element storage in a synchronous memory
    logic [IDX_W-1:0]   r_front, n_front;
    logic [IDX_W-1:0]   r_rear, n_rear;
    logic               r_empty, n_empty;
    logic [OCC_W-1:0]   r_count, n_count;

    // result stage
    logic               r_valid;
    t_status            r_status, n_status;
    logic               r_del_ok, n_del_ok;
    logic [OCC_W-1:0]   r_occ;
    logic               r_busy;

    logic [STORE_W-1:0] mem [DEPTH];
    logic [STORE_W-1:0] r_rd;

    logic               accept;
    t_func              func;
    logic               full;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_idx;

    assign accept = start && !r_busy;
    assign func   = t_func'(i_func);
    assign full   = !r_empty && (r_front == '0) && (r_rear == LAST_IDX);

    // operation decode: pointer moves, memory access and status
    always_comb begin
        n_front  = r_front;
        n_rear   = r_rear;
        n_empty  = r_empty;
        n_count  = r_count;
        n_status = ST_OK;
        n_del_ok = 1'b0;
        wr_en    = 1'b0;
        wr_idx   = r_front;
        rd_en    = 1'b0;
        rd_idx   = r_front;
        unique case (func)
            FN_INS_FRONT, FN_INS_REAR: begin
                priority if (full) begin
                    n_status = ST_FULL;
                end else if (r_empty) begin
                    // first element always lands at index 0
                    n_front = '0;
                    n_rear  = '0;
                    n_empty = 1'b0;
                    n_count = OCC_W'(1);
                    wr_en   = 1'b1;
                    wr_idx  = '0;
                end else if (func == FN_INS_FRONT) begin
                    if (r_front == '0) begin
                        n_status = ST_NO_ROOM;
                    end else begin
                        n_front = r_front - IDX_W'(1);
                        n_count = r_count + OCC_W'(1);
                        wr_en   = 1'b1;
                        wr_idx  = r_front - IDX_W'(1);
                    end
                end else begin
                    if (r_rear == LAST_IDX) begin
                        n_status = ST_NO_ROOM;
                    end else begin
                        n_rear  = r_rear + IDX_W'(1);
                        n_count = r_count + OCC_W'(1);
                        wr_en   = 1'b1;
                        wr_idx  = r_rear + IDX_W'(1);
                    end
                end
            end
            FN_DEL_FRONT, FN_DEL_REAR: begin
                priority if (r_empty) begin
                    n_status = ST_EMPTY;
                end else if (r_front == r_rear) begin
                    // last element out: back to the reset shape
                    rd_en    = 1'b1;
                    rd_idx   = r_front;
                    n_del_ok = 1'b1;
                    n_front  = '0;
                    n_rear   = '0;
                    n_empty  = 1'b1;
                    n_count  = '0;
                end else if (func == FN_DEL_FRONT) begin
                    rd_en    = 1'b1;
                    rd_idx   = r_front;
                    n_del_ok = 1'b1;
                    n_front  = r_front + IDX_W'(1);
                    n_count  = r_count - OCC_W'(1);
                end else begin
                    rd_en    = 1'b1;
                    rd_idx   = r_rear;
                    n_del_ok = 1'b1;
                    n_rear   = r_rear - IDX_W'(1);
                    n_count  = r_count - OCC_W'(1);
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_rear  <= '0;
            r_empty <= 1'b1;
            r_count <= '0;
            r_valid <= 1'b0;
            r_busy  <= 1'b1;
        end else begin
            r_busy  <= 1'b0;
            r_valid <= accept;
            if (accept) begin
                r_front <= n_front;
                r_rear  <= n_rear;
                r_empty <= n_empty;
                r_count <= n_count;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= n_status;
            r_del_ok <= n_del_ok;
            r_occ    <= n_count;
        end
    end

    // entry memory: one write or one registered read per item; a read of an
    // entry written by the previous item sees the new data, as the write lands
    // at the earlier edge
    always_ff @(posedge i_clk) begin
        if (accept && wr_en) begin
            mem[wr_idx] <= i_value[STORE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && rd_en) begin
            r_rd <= mem[rd_idx];
        end
    end

    assign busy            = r_busy;
    assign o_valid         = r_valid;
    assign o_status        = r_status;
    assign o_removed_value = r_del_ok ? VALUE_W'(r_rd) : '0;
    assign o_occupancy     = r_occ;

endmodule

`default_nettype wire

>>> rtl/ldq_checker.sv
// ldq_checker: port-level checks on the linear array deque results
// depends on ldq_pkg; bound to linear_array_deque_top below
`default_nettype none

module ldq_checker #(
    parameter int DEPTH = ldq_pkg::DEPTH_DEF,
    parameter int OCC_W = $clog2(DEPTH + 1)
) (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic                          o_valid,
    input wire logic [ldq_pkg::STATUS_W-1:0]  o_status,
    input wire logic [ldq_pkg::VALUE_W-1:0]   o_removed_value,
    input wire logic [OCC_W-1:0]              o_occupancy
);
    import ldq_pkg::*;

    // one result per item, in the cycle after it is taken
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_valid)
        else $error("item taken without a result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_valid)
        else $error("result without an item");

    // only a successful delete carries a value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_removed_value == '0))
        else $error("failed item carries a removed value");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_occupancy == OCC_W'(DEPTH)))
        else $error("full status with occupancy below depth");

    a_empty_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_EMPTY) |-> (o_occupancy == '0))
        else $error("empty status with elements held");

endmodule

bind linear_array_deque_top ldq_checker #(
    .DEPTH (DEPTH),
    .OCC_W (OCC_W)
) u_ldq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_valid         (o_valid),
    .o_status        (o_status),
    .o_removed_value (o_removed_value),
    .o_occupancy     (o_occupancy)
);

`default_nettype wire
